>>> src/rmmc_pkg.sv
// Shared types, constants and helper functions of the rover motion mode controller.
package rmmc_pkg;

  localparam int unsigned SPEED_W   = 7;
  localparam int unsigned HEADING_W = 9;
  localparam int unsigned DIST_W    = 16;
  localparam int unsigned CORR_W    = 8;
  localparam int unsigned NUM_MOTORS = 3;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [SPEED_W-1:0] TURN_SPEED_RST = 7'd30;
  localparam logic [SPEED_W-1:0] MOVE_SPEED_RST = 7'd40;
  localparam logic [SPEED_W-1:0] STOP_THR_RST   = 7'd30;
  localparam logic [SPEED_W-1:0] SPEED_MAX      = 7'd127;

  // Motor packet addresses are MOTOR_ADDR_BASE + motor number.
  localparam logic [7:0] MOTOR_ADDR_BASE = 8'd128;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_MOVING  = 2'd1,
    MODE_TURNING = 2'd2,
    MODE_WAITING = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_SENSORS = 2'd0,
    OP_NAV     = 2'd1,
    OP_ARM     = 2'd2,
    OP_PID     = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TURN_SPEED = 2'd0,
    CFG_MOVE_SPEED = 2'd1,
    CFG_STOP_THR   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [SPEED_W-1:0] turn_speed;
    logic [SPEED_W-1:0] move_speed;
    logic [SPEED_W-1:0] stop_threshold;
  } cfg_t;

  typedef struct packed {
    opcode_t               opcode;
    logic [HEADING_W-1:0]  sensor_heading;
    logic                  collision_flag;
    logic [HEADING_W-1:0]  goal_heading;
    logic [DIST_W-1:0]     goal_distance;
    logic                  arm_request;
    logic signed [CORR_W-1:0] speed_correction;
  } item_t;

  typedef struct packed {
    mode_t                                mode;
    logic [SPEED_W-1:0]                   speed;
    logic [HEADING_W-1:0]                 heading;
    logic [HEADING_W-1:0]                 tgt_heading;
    logic [DIST_W-1:0]                    tgt_dist;
    logic [NUM_MOTORS-1:0]                pkt_dir;
    logic [NUM_MOTORS-1:0][SPEED_W-1:0]   pkt_speed;
  } state_t;

  // Packet checksum: (address + direction + speed) kept to seven bits.
  function automatic logic [SPEED_W-1:0] pkt_check(input logic [1:0] motor,
                                                   input logic dir,
                                                   input logic [SPEED_W-1:0] spd);
    logic [SPEED_W-1:0] sum;
    sum = MOTOR_ADDR_BASE[SPEED_W-1:0] + {5'd0, motor} + {6'd0, dir} + spd;
    return sum;
  endfunction

endpackage

>>> src/rmmc_cfg.sv
// Configuration register bank of the rover motion mode controller.
module rmmc_cfg
  import rmmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [SPEED_W-1:0]   wr_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.turn_speed     <= TURN_SPEED_RST;
      cfg.move_speed     <= MOVE_SPEED_RST;
      cfg.stop_threshold <= STOP_THR_RST;
    end else if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        CFG_TURN_SPEED: cfg.turn_speed     <= wr_data;
        CFG_MOVE_SPEED: cfg.move_speed     <= wr_data;
        CFG_STOP_THR:   cfg.stop_threshold <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

>>> src/rmmc_step.sv
// Next-state logic of the mode machine for one message.
module rmmc_step
  import rmmc_pkg::*;
(
  input  item_t  item,
  input  state_t st,
  input  cfg_t   cfg,
  output state_t st_next
);

  logic [HEADING_W-1:0]  heading_n;
  logic signed [9:0]     diff;
  logic                  stop_hit;
  logic [HEADING_W-1:0]  th;
  logic [DIST_W-1:0]     td;
  mode_t                 idle_mode;

  assign heading_n = (item.opcode == OP_SENSORS) ? item.sensor_heading : st.heading;
  // Speed is 0..127 and the correction -128..127, so ten signed bits hold the difference.
  assign diff     = $signed({3'b000, st.speed}) - $signed({{2{item.speed_correction[7]}},
                                                           item.speed_correction});
  assign stop_hit = diff <= $signed({3'b000, cfg.stop_threshold});

  always_comb begin
    st_next         = st;
    st_next.heading = heading_n;
    th              = st.tgt_heading;
    td              = st.tgt_dist;
    idle_mode       = MODE_IDLE;

    case (st.mode)
      MODE_IDLE: begin
        // The arm request is taken first; a pending turn or move overrides it.
        if (item.opcode == OP_NAV) begin
          th = item.goal_heading;
          td = item.goal_distance;
        end else if (item.opcode == OP_ARM && item.arm_request) begin
          idle_mode = MODE_WAITING;
        end
        st_next.mode        = idle_mode;
        st_next.tgt_heading = th;
        st_next.tgt_dist    = td;
        if (th != heading_n) begin
          st_next.speed = cfg.turn_speed;
          st_next.mode  = MODE_TURNING;
        end else if (td != '0) begin
          st_next.tgt_dist = '0;
          st_next.speed    = cfg.move_speed;
          st_next.mode     = MODE_MOVING;
        end
      end
      MODE_MOVING: begin
        if (item.opcode == OP_PID) begin
          if (stop_hit) begin
            st_next.tgt_dist = '0;
            st_next.speed    = '0;
            st_next.mode     = MODE_IDLE;
          end else if (diff > $signed({3'b000, SPEED_MAX})) begin
            st_next.speed = SPEED_MAX;
          end else begin
            st_next.speed = diff[SPEED_W-1:0];
          end
        end else if (item.opcode == OP_SENSORS && item.collision_flag) begin
          st_next.speed = '0;
          st_next.mode  = MODE_IDLE;
        end
        st_next.pkt_dir      = 3'b001;
        st_next.pkt_speed[0] = st_next.speed;
        st_next.pkt_speed[1] = st_next.speed;
        st_next.pkt_speed[2] = '0;
      end
      MODE_TURNING: begin
        if (st.tgt_heading == heading_n) begin
          st_next.speed = '0;
          st_next.mode  = MODE_IDLE;
        end else begin
          st_next.pkt_dir   = (st.tgt_heading > heading_n) ? 3'b000 : 3'b111;
          st_next.pkt_speed = {NUM_MOTORS{st.speed}};
        end
      end
      default: begin
        if (item.opcode == OP_ARM && !item.arm_request) st_next.mode = MODE_IDLE;
      end
    endcase
  end

endmodule

>>> src/rover_motion_mode_controller.sv
// Top level of the rover motion mode controller: input stage, mode state and result word.
//
//  channel | signals                                | word
//  --------+----------------------------------------+---------------------------------
//  s_*     | s_tvalid s_tready s_tuser s_tdata      | one message in
//  m_*     | m_tvalid m_tready m_tdata              | mode, speed, heading, 3 packets
//  cfg_*   | cfg_valid cfg_ready cfg_index cfg_data | register write
//
// A message is held in the input register and is then applied to the state register; the
// updated state register is the result word, and one message can be taken every cycle while
// m_tready does not stall the result. The rate is set by the state update loop.
// Reset clears the input stage and sets mode idle, speed, heading, target and packets to zero.
// While a result waits, the input register still fills; only then is s_tready dropped.
module rover_motion_mode_controller
  import rmmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [1:0]            s_tuser,   // opcode
  // sensor_heading, collision_flag, goal_heading, goal_distance, arm_request,
  // speed_correction, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // mode_now, speed_now, heading_now, m1_direction, m1_speed, m1_check,
  // m2_direction, m2_speed, m2_check, m3_direction, m3_speed, m3_check, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SPEED_W-1:0]    cfg_data
);

  cfg_t   cfg;
  item_t  in_item;
  logic   in_valid;
  state_t st;
  state_t st_next;
  logic   load;
  logic   [SPEED_W-1:0] chk1, chk2, chk3;

  assign cfg_ready = 1'b1;

  rmmc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The result register is free when empty or when its word leaves this cycle.
  assign load     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.opcode           <= opcode_t'(s_tuser);
      in_item.sensor_heading   <= s_tdata[8:0];
      in_item.collision_flag   <= s_tdata[9];
      in_item.goal_heading     <= s_tdata[18:10];
      in_item.goal_distance    <= s_tdata[34:19];
      in_item.arm_request      <= s_tdata[35];
      in_item.speed_correction <= s_tdata[43:36];
    end
  end

  rmmc_step u_step (
    .item    (in_item),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next)
  );

  // An all-zero state is mode idle with every packet cleared.
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) st <= st_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign chk1 = pkt_check(2'd0, st.pkt_dir[0], st.pkt_speed[0]);
  assign chk2 = pkt_check(2'd1, st.pkt_dir[1], st.pkt_speed[1]);
  assign chk3 = pkt_check(2'd2, st.pkt_dir[2], st.pkt_speed[2]);

  assign m_tdata = {1'b0,
                    chk3, st.pkt_speed[2], st.pkt_dir[2],
                    chk2, st.pkt_speed[1], st.pkt_dir[1],
                    chk1, st.pkt_speed[0], st.pkt_dir[0],
                    st.heading, st.speed, st.mode};

  // A straight move always starts with its distance consumed.
  a_moving_dist_clear: assert property (@(posedge clk) disable iff (rst)
    st.mode == MODE_MOVING |-> st.tgt_dist == '0)
    else $error("moving with a nonzero target distance");

  // State changes only when a message is applied.
  a_state_only_on_load: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(st))
    else $error("state changed without a message");

  // With both stages full and the result stalled, no new message may enter.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while both stages are full");

endmodule
